FILE: rtl/pixel_downscale_char_quantizer_assert.svh
// assertion macros for the pixel downscale character quantizer
`ifndef PIXEL_DOWNSCALE_CHAR_QUANTIZER_ASSERT_SVH
`define PIXEL_DOWNSCALE_CHAR_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define PDCQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pdcq assertion failed");
// condition must never be true outside reset
`define PDCQ_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pdcq never-condition seen");
`else
`define PDCQ_ASSERT(name, clk, rst_n, prop)
`define PDCQ_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

FILE: rtl/pdcq_pkg.sv
// shared types and constants of the pixel downscale character quantizer
`default_nettype none

package pdcq_pkg;

  // default largest source dimension
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  // fixed field widths
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned CELL_W      = 12;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned LEVEL_CFG_W = 9;

  // register reset values
  localparam int unsigned SRC_W_RST  = 640;
  localparam int unsigned SRC_H_RST  = 480;
  localparam int unsigned GRID_W_RST = 80;
  localparam int unsigned GRID_H_RST = 40;
  localparam int unsigned LEVELS_RST = 70;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_GRID_WIDTH    = 3'd2,
    CFG_GRID_HEIGHT   = 3'd3,
    CFG_LEVEL_COUNT   = 3'd4
  } cfg_index_e;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [LEVEL_W-1:0]   level_t;

endpackage

`default_nettype wire

FILE: rtl/pixel_downscale_char_quantizer.sv
// Pixel stream downscaler that samples cell centers and quantizes gray to a character level.
//
// Usage:
//   Pixels (red_i, green_i, blue_i) enter in raster order on the in_valid_i /
//   in_ready_o request channel. Pixels under a cell center produce one result
//   on out_valid_o / out_ready_i carrying cell coordinates, the color, the
//   character level and frame_last on the final cell; all other pixels are
//   consumed without a result.
//   Pipeline: a result passes the sampling stage, loaded at the accepting
//   edge, then the output register. Throughput: one pixel per cycle,
//   limited only by the two-entry pipe of sampling stage and output
//   register.
//   Stall: when out_ready_i is low and both registers hold results, in_ready_o
//   drops for pixels that would produce a result; other pixels still flow.
//   Configuration: cfg_we_i writes register cfg_index_i with cfg_data_i at
//   once; any write restarts the frame position. Write only while idle.
//   Reset: registers return to 640x480 source, 80x40 grid, 70 levels, and the
//   frame position restarts at the first pixel.
`default_nettype none
`include "pixel_downscale_char_quantizer_assert.svh"

module pixel_downscale_char_quantizer #(
  parameter int unsigned MAX_DIMENSION = pdcq_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire pdcq_pkg::cfg_index_t cfg_index_i,
  input  wire pdcq_pkg::cfg_data_t cfg_data_i,
  // pixel input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pdcq_pkg::color_t    red_i,
  input  wire pdcq_pkg::color_t    green_i,
  input  wire pdcq_pkg::color_t    blue_i,
  // cell result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pdcq_pkg::cell_t          cell_column_o,
  output pdcq_pkg::cell_t          cell_row_o,
  output pdcq_pkg::level_t         char_level_o,
  output pdcq_pkg::color_t         out_red_o,
  output pdcq_pkg::color_t         out_green_o,
  output pdcq_pkg::color_t         out_blue_o,
  output logic                     frame_last_o
);

  import pdcq_pkg::*;

  // widths following from the largest dimension
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
  localparam int unsigned CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int unsigned ACC_W = 2 * DIM_W + 1;

  // effective sizes after reset
  localparam int unsigned RST_W  = (SRC_W_RST > MAX_DIMENSION) ? MAX_DIMENSION : SRC_W_RST;
  localparam int unsigned RST_H  = (SRC_H_RST > MAX_DIMENSION) ? MAX_DIMENSION : SRC_H_RST;
  localparam int unsigned RST_GW = (GRID_W_RST > RST_W) ? RST_W : GRID_W_RST;
  localparam int unsigned RST_GH = (GRID_H_RST > RST_H) ? RST_H : GRID_H_RST;
  localparam int unsigned RST_LM1 = LEVELS_RST - 1;

  // clamp a size to 1..hi
  function automatic logic [CMP_W-1:0] clamp_dim(input logic [CMP_W-1:0] v,
                                                 input logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] res;
    if (v == '0) begin
      res = CMP_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // raw configuration registers
  logic [CFG_W-1:0]       src_w_q, src_w_d;
  logic [CFG_W-1:0]       src_h_q, src_h_d;
  logic [CFG_W-1:0]       grid_w_q, grid_w_d;
  logic [CFG_W-1:0]       grid_h_q, grid_h_d;
  logic [LEVEL_CFG_W-1:0] levels_q, levels_d;

  // effective sizes
  logic [DIM_W-1:0]   eff_w_q, eff_w_d;
  logic [DIM_W-1:0]   eff_h_q, eff_h_d;
  logic [DIM_W-1:0]   eff_gw_q, eff_gw_d;
  logic [DIM_W-1:0]   eff_gh_q, eff_gh_d;
  logic [LEVEL_W-1:0] lm1_q, lm1_d;
  logic [CMP_W-1:0]   w_c, h_c, gw_c, gh_c;

  // register write decode
  always_comb begin
    src_w_d  = src_w_q;
    src_h_d  = src_h_q;
    grid_w_d = grid_w_q;
    grid_h_d = grid_h_q;
    levels_d = levels_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SOURCE_WIDTH:  src_w_d  = cfg_data_i;
        CFG_SOURCE_HEIGHT: src_h_d  = cfg_data_i;
        CFG_GRID_WIDTH:    grid_w_d = cfg_data_i;
        CFG_GRID_HEIGHT:   grid_h_d = cfg_data_i;
        CFG_LEVEL_COUNT:   levels_d = cfg_data_i[LEVEL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size clamping
  always_comb begin
    w_c  = clamp_dim(CMP_W'(src_w_d), CMP_W'(MAX_DIMENSION));
    h_c  = clamp_dim(CMP_W'(src_h_d), CMP_W'(MAX_DIMENSION));
    gw_c = clamp_dim(CMP_W'(grid_w_d), w_c);
    gh_c = clamp_dim(CMP_W'(grid_h_d), h_c);
    eff_w_d  = DIM_W'(w_c);
    eff_h_d  = DIM_W'(h_c);
    eff_gw_d = DIM_W'(gw_c);
    eff_gh_d = DIM_W'(gh_c);
    if (levels_d == '0) begin
      lm1_d = '0;
    end else if (levels_d > LEVEL_CFG_W'(256)) begin
      lm1_d = LEVEL_W'(255);
    end else begin
      lm1_d = LEVEL_W'(levels_d - LEVEL_CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= CFG_W'(SRC_W_RST);
      src_h_q  <= CFG_W'(SRC_H_RST);
      grid_w_q <= CFG_W'(GRID_W_RST);
      grid_h_q <= CFG_W'(GRID_H_RST);
      levels_q <= LEVEL_CFG_W'(LEVELS_RST);
      eff_w_q  <= DIM_W'(RST_W);
      eff_h_q  <= DIM_W'(RST_H);
      eff_gw_q <= DIM_W'(RST_GW);
      eff_gh_q <= DIM_W'(RST_GH);
      lm1_q    <= LEVEL_W'(RST_LM1);
    end else begin
      src_w_q  <= src_w_d;
      src_h_q  <= src_h_d;
      grid_w_q <= grid_w_d;
      grid_h_q <= grid_h_d;
      levels_q <= levels_d;
      eff_w_q  <= eff_w_d;
      eff_h_q  <= eff_h_d;
      eff_gw_q <= eff_gw_d;
      eff_gh_q <= eff_gh_d;
      lm1_q    <= lm1_d;
    end
  end

  // frame position state
  logic [CNT_W-1:0] src_col_q, src_col_d;
  logic [CNT_W-1:0] src_row_q, src_row_d;
  logic [DIM_W-1:0] cell_col_q, cell_col_d;
  logic [DIM_W-1:0] cell_row_q, cell_row_d;
  // center numerators and running bounds 2*g*(src+1)
  logic [ACC_W-1:0] col_target_q, col_target_d;
  logic [ACC_W-1:0] row_target_q, row_target_d;
  logic [ACC_W-1:0] col_bound_q, col_bound_d;
  logic [ACC_W-1:0] row_bound_q, row_bound_d;

  logic [ACC_W-1:0] two_w, two_h, two_gw, two_gh;
  logic             row_hit, col_hit, row_end, frame_end, cell_last;
  logic             accept;

  // sample decision for the current pixel
  always_comb begin
    two_w     = ACC_W'(eff_w_q) << 1;
    two_h     = ACC_W'(eff_h_q) << 1;
    two_gw    = ACC_W'(eff_gw_q) << 1;
    two_gh    = ACC_W'(eff_gh_q) << 1;
    row_hit   = (cell_row_q < eff_gh_q) && (row_target_q < row_bound_q);
    col_hit   = row_hit && (cell_col_q < eff_gw_q) && (col_target_q < col_bound_q);
    row_end   = (DIM_W'(src_col_q) + DIM_W'(1)) >= eff_w_q;
    frame_end = row_end && ((DIM_W'(src_row_q) + DIM_W'(1)) >= eff_h_q);
    cell_last = ((cell_col_q + DIM_W'(1)) == eff_gw_q) &&
                ((cell_row_q + DIM_W'(1)) == eff_gh_q);
  end

  // position update per pixel, restart on any register write
  always_comb begin
    src_col_d    = src_col_q;
    src_row_d    = src_row_q;
    cell_col_d   = cell_col_q;
    cell_row_d   = cell_row_q;
    col_target_d = col_target_q;
    row_target_d = row_target_q;
    col_bound_d  = col_bound_q;
    row_bound_d  = row_bound_q;
    if (cfg_we_i) begin
      src_col_d    = '0;
      src_row_d    = '0;
      cell_col_d   = '0;
      cell_row_d   = '0;
      col_target_d = ACC_W'(eff_w_d);
      row_target_d = ACC_W'(eff_h_d);
      col_bound_d  = ACC_W'(eff_gw_d) << 1;
      row_bound_d  = ACC_W'(eff_gh_d) << 1;
    end else if (accept) begin
      if (col_hit) begin
        cell_col_d   = cell_col_q + DIM_W'(1);
        col_target_d = col_target_q + two_w;
      end
      col_bound_d = col_bound_q + two_gw;
      if (row_end) begin
        src_col_d    = '0;
        cell_col_d   = '0;
        col_target_d = ACC_W'(eff_w_q);
        col_bound_d  = two_gw;
        if (row_hit) begin
          cell_row_d   = cell_row_q + DIM_W'(1);
          row_target_d = row_target_q + two_h;
        end
        row_bound_d = row_bound_q + two_gh;
        if (frame_end) begin
          src_row_d    = '0;
          cell_row_d   = '0;
          row_target_d = ACC_W'(eff_h_q);
          row_bound_d  = two_gh;
        end else begin
          src_row_d = src_row_q + CNT_W'(1);
        end
      end else begin
        src_col_d = src_col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q    <= '0;
      src_row_q    <= '0;
      cell_col_q   <= '0;
      cell_row_q   <= '0;
      col_target_q <= ACC_W'(RST_W);
      row_target_q <= ACC_W'(RST_H);
      col_bound_q  <= ACC_W'(2 * RST_GW);
      row_bound_q  <= ACC_W'(2 * RST_GH);
    end else begin
      src_col_q    <= src_col_d;
      src_row_q    <= src_row_d;
      cell_col_q   <= cell_col_d;
      cell_row_q   <= cell_row_d;
      col_target_q <= col_target_d;
      row_target_q <= row_target_d;
      col_bound_q  <= col_bound_d;
      row_bound_q  <= row_bound_d;
    end
  end

  // pipeline handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, s1_free;

  always_comb begin
    s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
    s1_free    = !s1_valid_q || s1_adv;
    in_ready_o = s1_free || !col_hit;
    accept     = in_valid_i && in_ready_o;
    if (accept && col_hit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // gray = floor(sum / 3) via reciprocal 683 / 2048, exact for sums up to 765
  logic [9:0]  rgb_sum;
  logic [19:0] gray_prod;
  logic [7:0]  gray;

  always_comb begin
    rgb_sum   = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    gray_prod = 20'(rgb_sum) * 20'd683;
    gray      = gray_prod[18:11];
  end

  // sampling stage register
  logic [DIM_W-1:0] s1_col_q, s1_row_q;
  color_t           s1_red_q, s1_green_q, s1_blue_q;
  logic [7:0]       s1_gray_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i) begin
    if (accept && col_hit) begin
      s1_col_q   <= cell_col_q;
      s1_row_q   <= cell_row_q;
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_gray_q  <= gray;
      s1_last_q  <= cell_last;
    end
  end

  // level = floor(gray * (levels - 1) / 255), divide by 255 as (x + 1 + x/256) / 256
  logic [15:0] level_prod;
  logic [16:0] level_sum;
  level_t      level;

  always_comb begin
    level_prod = 16'(s1_gray_q) * 16'(lm1_q);
    level_sum  = 17'(level_prod) + 17'd1 + 17'(level_prod[15:8]);
    level      = level_sum[15:8];
  end

  // output register
  cell_t  col_out_q, row_out_q;
  level_t level_out_q;
  color_t red_out_q, green_out_q, blue_out_q;
  logic   last_out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      col_out_q   <= CELL_W'(s1_col_q);
      row_out_q   <= CELL_W'(s1_row_q);
      level_out_q <= level;
      red_out_q   <= s1_red_q;
      green_out_q <= s1_green_q;
      blue_out_q  <= s1_blue_q;
      last_out_q  <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_column_o = col_out_q;
  assign cell_row_o    = row_out_q;
  assign char_level_o  = level_out_q;
  assign out_red_o     = red_out_q;
  assign out_green_o   = green_out_q;
  assign out_blue_o    = blue_out_q;
  assign frame_last_o  = last_out_q;

  // source column always inside the current row
  `PDCQ_ASSERT(a_src_col_in_row, clk_i, rst_ni, DIM_W'(src_col_q) < eff_w_q)
  // grid never wider than the source and never empty
  `PDCQ_ASSERT(a_grid_fits, clk_i, rst_ni, (eff_gw_q <= eff_w_q) && (eff_gw_q != '0))
  // a sampled pixel always lands in the sampling stage
  `PDCQ_ASSERT(a_hit_enters_stage, clk_i, rst_ni, accept && col_hit |=> s1_valid_q)
  // last pixel of a frame wraps the position
  `PDCQ_ASSERT(a_frame_wrap, clk_i, rst_ni,
    accept && frame_end && !cfg_we_i |=> (src_row_q == '0) && (cell_row_q == '0))
  // cell column never passes the grid width
  `PDCQ_ASSERT_NEVER(a_cell_col_range, clk_i, rst_ni, cell_col_q > eff_gw_q)

endmodule

`default_nettype wire
